// ----- sv/pcg_pkg.sv -----
// shared types, constants and arithmetic helpers for the pixel color grade block
package pcg_pkg;

    localparam int CH_W        = 13;
    localparam int ONE         = 4096;
    localparam int HALF        = 2048;
    localparam int CURVE_DEPTH = 256;
    localparam int IDX_W       = $clog2(CURVE_DEPTH);
    localparam int NSTAGE      = 20;

    localparam logic [1:0] CMD_PIXEL = 2'd0;
    localparam logic [1:0] CMD_CURVE = 2'd1;
    localparam logic [1:0] CMD_WHEEL = 2'd2;

    localparam logic [2:0] REG_WHITE_BALANCE   = 3'd0;
    localparam logic [2:0] REG_EXPOSURE_GAIN   = 3'd1;
    localparam logic [2:0] REG_CONTRAST_FACTOR = 3'd2;
    localparam logic [2:0] REG_SHADOW_LIFT     = 3'd3;
    localparam logic [2:0] REG_HIGHLIGHT_LIFT  = 3'd4;
    localparam logic [2:0] REG_SATURATION_GAIN = 3'd5;
    localparam logic [2:0] REG_VIBRANCE_AMOUNT = 3'd6;
    localparam logic [2:0] REG_MIX_AMOUNT      = 3'd7;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [7:0]         in_red;
        logic [7:0]         in_green;
        logic [7:0]         in_blue;
        logic [7:0]         in_alpha;
        logic [1:0]         table_select;
        logic [7:0]         table_index;
        logic [12:0]        curve_value;
        logic signed [15:0] wheel_red_delta;
        logic signed [15:0] wheel_green_delta;
        logic signed [15:0] wheel_blue_delta;
    } pcg_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } pcg_out_t;

    // item side data that rides along the pipeline
    typedef struct packed {
        logic [1:0]             cmd;
        logic [1:0]             sel;
        logic [IDX_W-1:0]       index;
        logic [CH_W-1:0]        value;
        logic [47:0]            wheel;
        logic [7:0]             alpha;
        logic [2:0][7:0]        px;
        logic [2:0][CH_W-1:0]   orig;
    } pcg_meta_t;

    function automatic logic [CH_W-1:0] clamp_q(input logic signed [31:0] x);
        logic [CH_W-1:0] r;
        if (x < 0) begin
            r = '0;
        end else if (x > ONE) begin
            r = CH_W'(ONE);
        end else begin
            r = x[CH_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] to_s32(input logic [CH_W-1:0] c);
        return $signed({{(32-CH_W){1'b0}}, c});
    endfunction

    function automatic logic signed [15:0] sat_q14(input logic [15:0] v);
        logic signed [15:0] s;
        logic signed [15:0] r;
        s = $signed(v);
        if (s > 16'sd16384) begin
            r = 16'sd16384;
        end else if (s < -16'sd16384) begin
            r = -16'sd16384;
        end else begin
            r = s;
        end
        return r;
    endfunction

    function automatic logic [CH_W-1:0] sq_rnd(input logic [CH_W-1:0] x);
        logic [2*CH_W-1:0] p;
        p = (2*CH_W)'(x) * (2*CH_W)'(x) + (2*CH_W)'(HALF);
        return CH_W'(p >> 12);
    endfunction

    function automatic logic [CH_W-1:0] luma(input logic [CH_W-1:0] r,
                                             input logic [CH_W-1:0] g,
                                             input logic [CH_W-1:0] b);
        logic [29:0] s;
        s = 30'(r) * 30'd19595 + 30'(g) * 30'd38470 + 30'(b) * 30'd7471 + 30'd32768;
        return CH_W'(s >> 16);
    endfunction

    function automatic logic [CH_W-1:0] min_one(input logic [CH_W-1:0] e);
        return (e > CH_W'(ONE)) ? CH_W'(ONE) : e;
    endfunction

    function automatic logic [IDX_W-1:0] curve_idx(input logic [CH_W-1:0] c);
        logic [20:0] p;
        p = 21'(c) * 21'd255 + 21'(HALF);
        return IDX_W'(p >> 12);
    endfunction

endpackage

// ----- sv/pcg_ram.sv -----
// generic simple dual port ram with registered read
module pcg_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/pixel_color_grade.sv -----
// pixel color grade top level: 20 stage grading pipeline with curve rams and wheel table
//
// One word on s_payload is a pixel (cmd 0), a curve entry write (cmd 1) or a
// tonal wheel write (cmd 2); cmd 3 is dropped. Only pixels return a word on
// m_payload. A pixel with zero alpha comes back with its bytes unchanged.
// Throughput is one word per cycle unless the output stalls. A pixel accepted
// at one clock edge passes the twenty register stages from unpremultiply
// through repremultiply before it shows up on m_valid. Table writes travel
// down the same pipeline and land in the curve rams and wheel table at the
// stage that reads them, so pixels always see the tables in arrival order. When
// m_ready is low with a result pending, every stage holds and s_ready drops; nothing
// is lost or repeated. The user writes registers on the cfg port only while the block
// is idle; the block does not enforce it. Reset clears the valid bits, the wheel table
// and the registers to their defaults; curve entries must be written before use.
module pixel_color_grade (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pcg_pkg::pcg_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output pcg_pkg::pcg_out_t m_payload,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    localparam int CW = pcg_pkg::CH_W;
    localparam int NS = pcg_pkg::NSTAGE;
    localparam int IW = pcg_pkg::IDX_W;

    // configuration registers
    logic [31:0] wb_reg;
    logic [16:0] gain_reg;
    logic [13:0] cf_reg;
    logic [15:0] sh_reg;
    logic [15:0] hl_reg;
    logic [14:0] satg_reg;
    logic [15:0] vib_reg;
    logic [12:0] mix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wb_reg   <= '0;
            gain_reg <= 17'd4096;
            cf_reg   <= 14'd4096;
            sh_reg   <= '0;
            hl_reg   <= '0;
            satg_reg <= 15'd4096;
            vib_reg  <= '0;
            mix_reg  <= 13'd4096;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pcg_pkg::REG_WHITE_BALANCE:   wb_reg   <= cfg_data;
                pcg_pkg::REG_EXPOSURE_GAIN:   gain_reg <= cfg_data[16:0];
                pcg_pkg::REG_CONTRAST_FACTOR: cf_reg   <= cfg_data[13:0];
                pcg_pkg::REG_SHADOW_LIFT:     sh_reg   <= cfg_data[15:0];
                pcg_pkg::REG_HIGHLIGHT_LIFT:  hl_reg   <= cfg_data[15:0];
                pcg_pkg::REG_SATURATION_GAIN: satg_reg <= cfg_data[14:0];
                pcg_pkg::REG_VIBRANCE_AMOUNT: vib_reg  <= cfg_data[15:0];
                pcg_pkg::REG_MIX_AMOUNT:      mix_reg  <= cfg_data[12:0];
            endcase
        end
    end

    // saturated views of the registers
    logic signed [15:0] temp_s, tint_s, sh_s, hl_s, vib_s;
    logic [16:0]        gain_s;
    logic [13:0]        cf_s;
    logic [14:0]        satg_s;
    logic [12:0]        mix_s;

    always_comb begin
        temp_s = pcg_pkg::sat_q14(wb_reg[15:0]);
        tint_s = pcg_pkg::sat_q14(wb_reg[31:16]);
        sh_s   = pcg_pkg::sat_q14(sh_reg);
        hl_s   = pcg_pkg::sat_q14(hl_reg);
        vib_s  = pcg_pkg::sat_q14(vib_reg);
        if (gain_reg < 17'd256) begin
            gain_s = 17'd256;
        end else if (gain_reg > 17'd65536) begin
            gain_s = 17'd65536;
        end else begin
            gain_s = gain_reg;
        end
        cf_s   = (cf_reg > 14'd12288) ? 14'd12288 : cf_reg;
        satg_s = (satg_reg > 15'd16384) ? 15'd16384 : satg_reg;
        mix_s  = (mix_reg > 13'd4096) ? 13'd4096 : mix_reg;
    end

    // pipeline control: every stage moves together
    logic en;
    logic m_valid_reg;
    logic valid_reg [NS];
    pcg_pkg::pcg_meta_t meta_reg [NS];
    pcg_pkg::pcg_meta_t meta0_next, meta1_next;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NS; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= s_valid;
            for (int k = 1; k < NS; k++) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_comb begin
        meta0_next.cmd   = s_payload.cmd;
        meta0_next.sel   = s_payload.table_select;
        meta0_next.index = s_payload.table_index;
        meta0_next.value = s_payload.curve_value;
        meta0_next.wheel = {pcg_pkg::sat_q14(s_payload.wheel_blue_delta),
                            pcg_pkg::sat_q14(s_payload.wheel_green_delta),
                            pcg_pkg::sat_q14(s_payload.wheel_red_delta)};
        meta0_next.alpha = s_payload.in_alpha;
        meta0_next.px    = {s_payload.in_blue, s_payload.in_green, s_payload.in_red};
        meta0_next.orig  = '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            meta_reg[0] <= meta0_next;
            meta_reg[1] <= meta1_next;
            for (int k = 2; k < NS; k++) begin
                meta_reg[k] <= meta_reg[k-1];
            end
        end
    end

    // reciprocal table for unpremultiply
    logic [28:0] recip_lut [256];
    for (genvar a = 0; a < 256; a++) begin : g_recip
        localparam int DIV = (a == 0) ? 1 : a;
        localparam int RV  = ((pcg_pkg::ONE << 16) + a / 2) / DIV;
        assign recip_lut[a] = 29'(RV);
    end

    // stage payload registers
    logic [2:0][CW-1:0] c1_reg, c1_next, c2_reg, c2_next, c3_reg, c3_next;
    logic [2:0][CW-1:0] c4_reg, c4_next, c5_reg, c6_reg, c7_reg, c8_reg, c8_next;
    logic [2:0][CW-1:0] c9_reg, c10_reg, c11_reg, c12_reg, c12_next;
    logic [2:0][CW-1:0] c13_reg, c14_reg, c15_reg, c16_reg, c16_next, c19_reg, c19_next;
    logic [CW-1:0]      l5_next, l5_reg, l9_next, l9_reg, l13_next, l13_reg;
    logic [CW-1:0]      l14_reg, l15_reg;
    logic [CW-1:0]      sw_next, sw_reg, hw_next, hw_reg;
    logic signed [27:0] ps_next, ps_reg, ph_next, ph_reg;
    logic [CW-1:0]      w1_next, w1_reg, w2_next, w2_reg, w3_next, w3_reg;
    logic [CW-1:0]      rng_next, rng_reg;
    logic [13:0]        vf_next, vf_reg;
    logic [15:0]        sf_next, sf_reg;
    logic signed [2:0][2:0][27:0] pr_next, pr_reg;
    logic signed [2:0][15:0]      t0_next, t0_reg;
    logic [3:0][47:0]   wheel_reg;

    // unpremultiply
    always_comb begin
        logic [28:0] recip;
        logic [36:0] p;
        logic [20:0] u;
        recip = recip_lut[meta_reg[0].alpha];
        for (int i = 0; i < 3; i++) begin
            p = 37'(meta_reg[0].px[i]) * 37'(recip) + 37'd32768;
            u = 21'(p >> 16);
            c1_next[i] = (u > 21'(pcg_pkg::ONE)) ? CW'(pcg_pkg::ONE) : u[CW-1:0];
        end
        meta1_next      = meta_reg[0];
        meta1_next.orig = c1_next;
    end

    // white balance
    always_comb begin
        logic signed [16:0] tt;
        logic signed [31:0] toff, m10, m05, t10, t05;
        tt   = 17'(temp_s) + 17'sd16;
        toff = 32'(tt >>> 5);
        m10  = 32'(tint_s) * 32'sd6554 + 32'sd131072;
        m05  = 32'(tint_s) * 32'sd3277 + 32'sd131072;
        t10  = m10 >>> 18;
        t05  = m05 >>> 18;
        c2_next[0] = pcg_pkg::clamp_q(pcg_pkg::to_s32(
                         pcg_pkg::clamp_q(pcg_pkg::to_s32(c1_reg[0]) + toff)) + t05);
        c2_next[2] = pcg_pkg::clamp_q(pcg_pkg::to_s32(
                         pcg_pkg::clamp_q(pcg_pkg::to_s32(c1_reg[2]) - toff)) + t05);
        c2_next[1] = pcg_pkg::clamp_q(pcg_pkg::to_s32(c1_reg[1]) - t10);
    end

    // exposure
    always_comb begin
        logic [29:0] p;
        logic [17:0] u;
        for (int i = 0; i < 3; i++) begin
            p = 30'(c2_reg[i]) * 30'(gain_s) + 30'(pcg_pkg::HALF);
            u = 18'(p >> 12);
            c3_next[i] = pcg_pkg::clamp_q($signed(32'(u)));
        end
    end

    // contrast about one half
    always_comb begin
        logic signed [31:0] d, p;
        for (int i = 0; i < 3; i++) begin
            d = pcg_pkg::to_s32(c3_reg[i]) - 32'sd2048;
            p = d * $signed({18'd0, cf_s});
            c4_next[i] = pcg_pkg::clamp_q(((p + 32'sd2048) >>> 12) + 32'sd2048);
        end
    end

    // luma, lift weights and lift products
    always_comb begin
        l5_next = pcg_pkg::luma(c4_reg[0], c4_reg[1], c4_reg[2]);
        sw_next = pcg_pkg::sq_rnd(CW'(pcg_pkg::ONE) - l5_reg);
        hw_next = pcg_pkg::sq_rnd(l5_reg);
        ps_next = 28'(sh_s) * $signed({15'd0, sw_reg});
        ph_next = 28'(hl_s) * $signed({15'd0, hw_reg});
    end

    // lift apply
    always_comb begin
        logic signed [43:0] ms, mh;
        logic signed [31:0] adj;
        ms  = 44'(ps_reg) * 44'sd22938 + 44'sd536870912;
        mh  = 44'(ph_reg) * 44'sd22938 + 44'sd536870912;
        adj = 32'(ms >>> 30) + 32'(mh >>> 30);
        for (int i = 0; i < 3; i++) begin
            c8_next[i] = pcg_pkg::clamp_q(pcg_pkg::to_s32(c7_reg[i]) + adj);
        end
    end

    // tonal wheel weights
    always_comb begin
        logic [13:0]   l2;
        logic [CW-1:0] dabs;
        l9_next = pcg_pkg::luma(c8_reg[0], c8_reg[1], c8_reg[2]);
        l2      = {l9_reg, 1'b0};
        dabs    = (l2 >= 14'(pcg_pkg::ONE)) ? CW'(l2 - 14'(pcg_pkg::ONE))
                                            : CW'(14'(pcg_pkg::ONE) - l2);
        w1_next = pcg_pkg::sq_rnd(CW'(pcg_pkg::ONE) - l9_reg);
        w2_next = CW'(pcg_pkg::ONE) - pcg_pkg::sq_rnd(dabs);
        w3_next = pcg_pkg::sq_rnd(l9_reg);
    end

    // wheel products; wheel writes land here so pixels see them in order
    always_comb begin
        logic signed [16:0] d0;
        for (int i = 0; i < 3; i++) begin
            d0 = 17'($signed(wheel_reg[0][16*i +: 16])) + 17'sd1;
            t0_next[i] = 16'(d0 >>> 1);
            pr_next[i][0] = 28'($signed(wheel_reg[1][16*i +: 16])) * $signed({15'd0, w1_reg});
            pr_next[i][1] = 28'($signed(wheel_reg[2][16*i +: 16])) * $signed({15'd0, w2_reg});
            pr_next[i][2] = 28'($signed(wheel_reg[3][16*i +: 16])) * $signed({15'd0, w3_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wheel_reg <= '0;
        end else if (en && valid_reg[10] && meta_reg[10].cmd == pcg_pkg::CMD_WHEEL) begin
            wheel_reg[meta_reg[10].sel] <= meta_reg[10].wheel;
        end
    end

    // elements of a packed array read back unsigned, so sign them again
    always_comb begin
        logic signed [31:0] acc;
        for (int i = 0; i < 3; i++) begin
            acc = pcg_pkg::to_s32(c11_reg[i]) + 32'($signed(t0_reg[i]));
            for (int k = 0; k < 3; k++) begin
                acc = acc + 32'(($signed(pr_reg[i][k]) + 28'sd4096) >>> 13);
            end
            c12_next[i] = pcg_pkg::clamp_q(acc);
        end
    end

    // saturation and vibrance
    always_comb begin
        logic [CW-1:0]      mx, mn;
        logic signed [31:0] q, v, d, qs;
        logic [28:0]        sp;
        l13_next = pcg_pkg::luma(c12_reg[0], c12_reg[1], c12_reg[2]);
        mx = c12_reg[0];
        mn = c12_reg[0];
        for (int i = 1; i < 3; i++) begin
            if (c12_reg[i] > mx) begin
                mx = c12_reg[i];
            end
            if (c12_reg[i] < mn) begin
                mn = c12_reg[i];
            end
        end
        rng_next = mx - mn;
        q  = 32'(vib_s) * $signed({19'd0, CW'(pcg_pkg::ONE) - rng_reg});
        v  = 32'sd4096 + ((q + 32'sd8192) >>> 14);
        vf_next = (v < 0) ? 14'd0 : 14'(v);
        sp = 29'(satg_s) * 29'(vf_reg) + 29'(pcg_pkg::HALF);
        sf_next = 16'(sp >> 12);
        for (int i = 0; i < 3; i++) begin
            d  = pcg_pkg::to_s32(c15_reg[i]) - pcg_pkg::to_s32(l15_reg);
            qs = d * $signed({16'd0, sf_reg});
            c16_next[i] = pcg_pkg::clamp_q(pcg_pkg::to_s32(l15_reg)
                                           + ((qs + 32'sd2048) >>> 12));
        end
    end

    // curve rams: the shared curve is copied once per channel
    logic [2:0][CW-1:0] rd_all, rd_ch;
    logic [2:0][IW-1:0] ra_all, ra_ch;
    logic [2:0]         we_all, we_ch;

    for (genvar i = 0; i < 3; i++) begin : g_curve
        assign ra_all[i] = pcg_pkg::curve_idx(c16_reg[i]);
        assign we_all[i] = en && valid_reg[16] && meta_reg[16].cmd == pcg_pkg::CMD_CURVE
                           && meta_reg[16].sel == 2'd0;
        assign ra_ch[i]  = pcg_pkg::curve_idx(pcg_pkg::min_one(rd_all[i]));
        assign we_ch[i]  = en && valid_reg[17] && meta_reg[17].cmd == pcg_pkg::CMD_CURVE
                           && meta_reg[17].sel == 2'(i + 1);

        pcg_ram #(.WIDTH(CW), .DEPTH(pcg_pkg::CURVE_DEPTH)) u_all (
            .aclk  (aclk),
            .we    (we_all[i]),
            .waddr (meta_reg[16].index),
            .wdata (meta_reg[16].value),
            .re    (en),
            .raddr (ra_all[i]),
            .rdata (rd_all[i])
        );

        pcg_ram #(.WIDTH(CW), .DEPTH(pcg_pkg::CURVE_DEPTH)) u_ch (
            .aclk  (aclk),
            .we    (we_ch[i]),
            .waddr (meta_reg[17].index),
            .wdata (meta_reg[17].value),
            .re    (en),
            .raddr (ra_ch[i]),
            .rdata (rd_ch[i])
        );
    end

    // mix with the original
    always_comb begin
        logic [25:0] p;
        for (int i = 0; i < 3; i++) begin
            p = 26'(meta_reg[18].orig[i]) * 26'(CW'(pcg_pkg::ONE) - mix_s)
              + 26'(pcg_pkg::min_one(rd_ch[i])) * 26'(mix_s) + 26'(pcg_pkg::HALF);
            c19_next[i] = pcg_pkg::clamp_q($signed(32'(p >> 12)));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg  <= c1_next;
            c2_reg  <= c2_next;
            c3_reg  <= c3_next;
            c4_reg  <= c4_next;
            c5_reg  <= c4_reg;
            l5_reg  <= l5_next;
            c6_reg  <= c5_reg;
            sw_reg  <= sw_next;
            hw_reg  <= hw_next;
            c7_reg  <= c6_reg;
            ps_reg  <= ps_next;
            ph_reg  <= ph_next;
            c8_reg  <= c8_next;
            c9_reg  <= c8_reg;
            l9_reg  <= l9_next;
            c10_reg <= c9_reg;
            w1_reg  <= w1_next;
            w2_reg  <= w2_next;
            w3_reg  <= w3_next;
            c11_reg <= c10_reg;
            pr_reg  <= pr_next;
            t0_reg  <= t0_next;
            c12_reg <= c12_next;
            c13_reg <= c12_reg;
            l13_reg <= l13_next;
            rng_reg <= rng_next;
            c14_reg <= c13_reg;
            l14_reg <= l13_reg;
            vf_reg  <= vf_next;
            c15_reg <= c14_reg;
            l15_reg <= l14_reg;
            sf_reg  <= sf_next;
            c16_reg <= c16_next;
            c19_reg <= c19_next;
        end
    end

    // repremultiply into the output register
    pcg_pkg::pcg_out_t out_next, out_reg;

    always_comb begin
        logic [20:0] pm [3];
        logic [7:0]  ob [3];
        for (int i = 0; i < 3; i++) begin
            pm[i] = 21'(c19_reg[i]) * 21'(meta_reg[NS-1].alpha) + 21'(pcg_pkg::HALF);
            ob[i] = (meta_reg[NS-1].alpha == 8'd0) ? meta_reg[NS-1].px[i] : 8'(pm[i] >> 12);
        end
        out_next.out_red   = ob[0];
        out_next.out_green = ob[1];
        out_next.out_blue  = ob[2];
        out_next.out_alpha = meta_reg[NS-1].alpha;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= valid_reg[NS-1] && meta_reg[NS-1].cmd == pcg_pkg::CMD_PIXEL;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_payload = out_reg;

`ifndef SYNTH
    a_table_word_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        en && valid_reg[NS-1] && meta_reg[NS-1].cmd != pcg_pkg::CMD_PIXEL |=> !m_valid)
        else $error("table word produced a result");

    a_alpha_carried: assert property (@(posedge aclk) disable iff (!aresetn)
        en && valid_reg[NS-1] && meta_reg[NS-1].cmd == pcg_pkg::CMD_PIXEL
        |=> m_valid && m_payload.out_alpha == $past(meta_reg[NS-1].alpha))
        else $error("pixel lost or alpha changed at output");

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(valid_reg[NS-1]) && $stable(valid_reg[0]))
        else $error("pipeline moved during stall");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> valid_reg[0])
        else $error("accepted word missing from first stage");
`endif

endmodule
